// ===== hw/rtl/open_addressing_hash_table_macros.svh =====
// Assertion macros used by the hash table RTL.
`ifndef OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OAHT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OAHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/oaht_pkg.sv =====
// Package: field widths, codes and defaults of the hash table.
package oaht_pkg;

	// Default sizes
	localparam int CAPACITY_DEF   = 1024;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Field widths on the ports
	localparam int CMD_W     = 2;
	localparam int KEY_W     = 32;
	localparam int HASH_W    = 32;
	localparam int VAL_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 10;
	localparam int COUNT_W   = 11;
	localparam int S_TDATA_W = KEY_W + HASH_W + VAL_W;
	localparam int M_FIELD_W = SLOT_W + VAL_W + COUNT_W;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

	// Limit register reset value
	localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = COUNT_W'(512);

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// Result status
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

	// Slot marks
	localparam int MARK_W = 2;
	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_SET   = 2'd2;

endpackage

// ===== hw/rtl/oaht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module oaht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/open_addressing_hash_table.sv =====
// Top level: open-addressing key/value table with triangular probing.
// Flow: on accept, serial hash reduction when CAPACITY is not a power of two (S_REDUCE),
// then a probe of 1 .. CAPACITY slots (S_PROBE), then the result is registered (S_FINISH).
// Throughput: one item at a time, since s_tready is high only in idle;
// a held result stalls the finish.
// Reset: clears control state, then sweeps every slot of the RAM empty before going idle.
`include "open_addressing_hash_table_macros.svh"

module open_addressing_hash_table #(
	parameter int CAPACITY   = oaht_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [oaht_pkg::COUNT_W-1:0]   cfg_wdata,  // max_entries
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [oaht_pkg::S_TDATA_W-1:0] s_tdata,    // key, hash, value
	input  logic [oaht_pkg::CMD_W-1:0]     s_tuser,    // command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [oaht_pkg::M_TDATA_W-1:0] m_tdata,    // slot, found_value, live_count, zero pad
	output logic [oaht_pkg::STATUS_W-1:0]  m_tuser     // status
);
	import oaht_pkg::*;

	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int SUM_W    = ADDR_W + 1;
	localparam int STEP_W   = $clog2(CAPACITY + 1);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int ROW_W    = MARK_W + KEY_BITS + VALUE_BITS;
	localparam int BIT_W    = $clog2(HASH_W);
	localparam bit CAP_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);
	localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(HASH_W - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_REDUCE,
		S_PROBE,
		S_FINISH
	} state_t;

	state_t                 state_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [HASH_W-1:0]      hash_q;
	logic [BIT_W-1:0]       bit_q;
	logic [ADDR_W-1:0]      red_q;
	logic [ADDR_W-1:0]      probe_idx_q;
	logic [STEP_W-1:0]      step_q;
	logic                   rd_valid_s1;
	logic [ADDR_W-1:0]      rd_idx_s1;
	logic [STEP_W-1:0]      rd_step_s1;
	logic                   hit_q;
	logic [ADDR_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0]  hit_val_q;
	logic                   free_q;
	logic [ADDR_W-1:0]      free_idx_q;
	logic [CNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]     max_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [VAL_W-1:0]       out_value_q;
	logic [COUNT_W-1:0]     out_count_q;

	// RAM ports
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [ROW_W-1:0]       ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [ROW_W-1:0]       ram_rdata;

	// slot row: mark, key, value from the top bit down
	oaht_ram #(
		.WIDTH(ROW_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// input fields
	logic                  accept;
	logic [KEY_BITS-1:0]   in_key;
	logic [HASH_W-1:0]     in_hash;
	logic [VALUE_BITS-1:0] in_val;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_key   = KEY_BITS'(s_tdata[KEY_W-1:0]);
	assign in_hash  = s_tdata[KEY_W +: HASH_W];
	assign in_val   = VALUE_BITS'(s_tdata[KEY_W + HASH_W +: VAL_W]);

	// hash mod CAPACITY, one hash bit per cycle, with one compare-subtract
	logic [SUM_W-1:0]  red_shift;
	logic [ADDR_W-1:0] red_next;

	always_comb begin
		red_shift = {red_q, hash_q[HASH_W-1]};
		red_next  = (red_shift >= SUM_W'(CAPACITY)) ?
			ADDR_W'(red_shift - SUM_W'(CAPACITY)) : ADDR_W'(red_shift);
	end

	// next probe slot: idx + (i + 1), wrapped once
	logic             issue;
	logic [SUM_W-1:0] probe_sum;
	logic [ADDR_W-1:0] idx_next;

	always_comb begin
		issue     = (state_q == S_PROBE) && (step_q < STEP_W'(CAPACITY));
		probe_sum = SUM_W'(probe_idx_q) + SUM_W'(step_q) + SUM_W'(1);
		idx_next  = (probe_sum >= SUM_W'(CAPACITY)) ?
			ADDR_W'(probe_sum - SUM_W'(CAPACITY)) : ADDR_W'(probe_sum);
	end

	// slot check on the read data
	logic [MARK_W-1:0]     rd_mark;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  chk;
	logic                  match;
	logic                  stop_empty;
	logic                  last_step;
	logic                  probe_done;
	logic                  take_free;

	always_comb begin
		rd_mark    = ram_rdata[ROW_W-1 -: MARK_W];
		rd_key     = ram_rdata[VALUE_BITS +: KEY_BITS];
		rd_val     = ram_rdata[VALUE_BITS-1:0];
		chk        = (state_q == S_PROBE) && rd_valid_s1;
		match      = chk && (rd_mark == MARK_SET) && (rd_key == key_q);
		stop_empty = chk && (rd_mark != MARK_SET) && (rd_mark != MARK_TOMB);
		last_step  = chk && (rd_step_s1 == STEP_W'(CAPACITY - 1));
		probe_done = match || stop_empty || last_step;
		take_free  = chk && !free_q && (rd_mark != MARK_SET);
	end

	// result and table update
	logic                  fin;
	logic                  full;
	logic [STATUS_W-1:0]   fin_status;
	logic [ADDR_W-1:0]     fin_slot;
	logic [VALUE_BITS-1:0] fin_val;
	logic [CNT_W-1:0]      cnt_next;
	logic                  fin_we;
	logic [ROW_W-1:0]      fin_row;
	logic [ADDR_W-1:0]     fin_addr;

	always_comb begin
		fin        = (state_q == S_FINISH) && (!out_valid_q || m_tready);
		full       = (CMP_W'(count_q) >= CMP_W'(max_q)) || !free_q;
		fin_status = ST_MISS;
		fin_slot   = '0;
		fin_val    = '0;
		cnt_next   = count_q;
		fin_we     = 1'b0;
		fin_addr   = hit_idx_q;
		fin_row    = {MARK_TOMB, key_q, val_q};
		case (cmd_q)
			CMD_INSERT: begin
				if (hit_q) begin
					fin_status = ST_DUP;
					fin_slot   = hit_idx_q;
					fin_val    = hit_val_q;
				end else if (full) begin
					fin_status = ST_FULL;
				end else begin
					fin_status = ST_OK;
					fin_slot   = free_idx_q;
					cnt_next   = count_q + CNT_W'(1);
					fin_we     = 1'b1;
					fin_addr   = free_idx_q;
					fin_row    = {MARK_SET, key_q, val_q};
				end
			end
			CMD_REMOVE: begin
				if (hit_q) begin
					fin_status = ST_OK;
					fin_slot   = hit_idx_q;
					fin_we     = 1'b1;
					if (count_q != '0) begin
						cnt_next = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
				// lookup, and the unused command code
				if (hit_q) begin
					fin_status = ST_OK;
					fin_slot   = hit_idx_q;
					fin_val    = hit_val_q;
				end
			end
		endcase
	end

	// RAM port muxing: clearing sweep or result write, probe reads
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = fin_addr;
		ram_wdata = fin_row;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = {MARK_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
		end else if (fin) begin
			ram_we = fin_we;
		end
		ram_re    = issue;
		ram_raddr = probe_idx_q;
	end

	// sequencer and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			cmd_q        <= CMD_LOOKUP;
			key_q        <= '0;
			val_q        <= '0;
			hash_q       <= '0;
			bit_q        <= '0;
			red_q        <= '0;
			probe_idx_q  <= '0;
			step_q       <= '0;
			rd_valid_s1  <= 1'b0;
			rd_idx_s1    <= '0;
			rd_step_s1   <= '0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			hit_val_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			count_q      <= '0;
			max_q        <= MAX_ENTRIES_RST;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_slot_q   <= '0;
			out_value_q  <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (m_tready && !fin) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline tracks the issued slot; a read issued as the probe ends is dropped
			rd_valid_s1 <= issue && !probe_done;
			rd_idx_s1   <= probe_idx_q;
			rd_step_s1  <= step_q;

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cmd_q       <= s_tuser;
						key_q       <= in_key;
						val_q       <= in_val;
						hash_q      <= in_hash;
						bit_q       <= '0;
						red_q       <= '0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						step_q      <= '0;
						probe_idx_q <= ADDR_W'(in_hash);
						state_q     <= CAP_POW2 ? S_PROBE : S_REDUCE;
					end
				end
				S_REDUCE: begin
					red_q  <= red_next;
					hash_q <= hash_q << 1;
					bit_q  <= bit_q + BIT_W'(1);
					if (bit_q == BIT_LAST) begin
						probe_idx_q <= red_next;
						state_q     <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (issue) begin
						probe_idx_q <= idx_next;
						step_q      <= step_q + STEP_W'(1);
					end
					if (take_free) begin
						free_q     <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
					if (match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						hit_val_q <= rd_val;
					end
					if (probe_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin) begin
						count_q      <= cnt_next;
						out_valid_q  <= 1'b1;
						out_status_q <= fin_status;
						out_slot_q   <= SLOT_W'(fin_slot);
						out_value_q  <= VAL_W'(fin_val);
						out_count_q  <= COUNT_W'(cnt_next);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_count_q, out_value_q, out_slot_q};

	// checks
	logic ins_ok;

	assign ins_ok = fin && (cmd_q == CMD_INSERT) && (fin_status == ST_OK);

	`OAHT_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`OAHT_ASSERT_IMPLY(a_read_range, ram_re, ram_raddr <= LAST_ADDR, "probe read out of range")
	`OAHT_ASSERT_NEXT(a_ins_count, ins_ok, count_q == $past(count_q) + CNT_W'(1), "count not grown")
	`OAHT_ASSERT_NEXT(a_result_load, fin, out_valid_q && (state_q == S_IDLE), "result not loaded")

endmodule
